FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold at every edge where the antecedent holds, outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

// Expression must hold at every edge while reset is asserted.
`define ASSERT_IN_RESET(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) !(rst_n) |-> (expr)) \
		else $error("%m: reset check failed");

`endif

FILE: design/tmc_pkg.sv
// Shared types and constants of the top-two margin classifier.
`timescale 1ns / 1ps

package tmc_pkg;

	localparam int CLASS_INDEX_W = 6;
	localparam int STATUS_W      = 2;
	localparam int CFG_INDEX_W   = 1;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_ACCEPT     = 2'd0;
	localparam status_t STATUS_NO_ABOVE   = 2'd1;
	localparam status_t STATUS_LOW_MARGIN = 2'd2;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t CFG_THRESHOLD     = 1'b0;
	localparam cfg_index_t CFG_MARGIN_BUFFER = 1'b1;

	typedef struct packed {
		logic valid;
		logic have_second;
		logic any_above;
	} row_flags_t;

endpackage

FILE: design/tmc_ifs.sv
// Channel interfaces: score requests, result requests and register writes.
`timescale 1ns / 1ps

interface tmc_score_if #(parameter int SCORE_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SCORE_WIDTH-1:0] score;
	logic                          last;

	modport source (output valid, output score, output last, input ready);
	modport sink   (input valid, input score, input last, output ready);
endinterface

interface tmc_result_if #(parameter int SCORE_WIDTH = 16);
	import tmc_pkg::*;
	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic [CLASS_INDEX_W-1:0] class_index;
	logic [SCORE_WIDTH-1:0]   margin;

	modport source (output valid, output status, output class_index, output margin,
		input ready);
	modport sink   (input valid, input status, input class_index, input margin,
		output ready);
endinterface

interface tmc_cfg_if #(parameter int SCORE_WIDTH = 16);
	import tmc_pkg::*;
	logic                   valid;
	logic                   ready;
	cfg_index_t             index;
	logic [SCORE_WIDTH-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/tmc_cfg_regs.sv
// Configuration registers: threshold and margin buffer.
`timescale 1ns / 1ps

module tmc_cfg_regs #(
	parameter int SCORE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tmc_cfg_if.sink                       cfg_ch,
	output logic signed [SCORE_WIDTH-1:0] threshold_q,
	output logic [SCORE_WIDTH-1:0]        margin_buffer_q
);
	import tmc_pkg::*;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q     <= '0;
			margin_buffer_q <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				CFG_THRESHOLD:     threshold_q     <= signed'(cfg_ch.data);
				CFG_MARGIN_BUFFER: margin_buffer_q <= cfg_ch.data;
				default: ;
			endcase
		end
	end

endmodule

FILE: design/tmc_row_track.sv
// Input stage and running best/second/threshold state over one row.
`timescale 1ns / 1ps

module tmc_row_track #(
	parameter int MAX_CLASSES = 64,
	parameter int SCORE_WIDTH = 16,
	localparam int IDX_W = $clog2(MAX_CLASSES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tmc_score_if.sink                     score_ch,
	input  logic                          advance,
	input  logic signed [SCORE_WIDTH-1:0] threshold,
	output tmc_pkg::row_flags_t           flags_s2,
	output logic signed [SCORE_WIDTH-1:0] best_s2,
	output logic signed [SCORE_WIDTH-1:0] second_s2,
	output logic [IDX_W-1:0]              best_pos_s2
);
	import tmc_pkg::*;

	localparam int POS_W = $clog2(MAX_CLASSES + 1);

	logic                          valid_s1;
	logic signed [SCORE_WIDTH-1:0] score_s1;
	logic                          last_s1;

	logic [POS_W-1:0]              pos_q, pos_n;
	logic                          have2_q, have2_n;
	logic                          any_q, any_n;
	logic signed [SCORE_WIDTH-1:0] best_q, best_n;
	logic signed [SCORE_WIDTH-1:0] second_q, second_n;
	logic [IDX_W-1:0]              bpos_q, bpos_n;
	logic                          in_range;
	logic                          step;

	assign score_ch.ready = advance;
	assign step           = advance && valid_s1;
	assign in_range       = pos_q < POS_W'(MAX_CLASSES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= score_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && score_ch.valid) begin
			score_s1 <= score_ch.score;
			last_s1  <= score_ch.last;
		end
	end

	// scores past MAX_CLASSES leave the state alone
	always_comb begin
		pos_n    = pos_q;
		have2_n  = have2_q;
		any_n    = any_q;
		best_n   = best_q;
		second_n = second_q;
		bpos_n   = bpos_q;
		if (in_range) begin
			pos_n = pos_q + POS_W'(1);
			any_n = any_q || (score_s1 > threshold);
			if (pos_q == '0) begin
				best_n = score_s1;
				bpos_n = '0;
			end else if (!have2_q) begin
				have2_n = 1'b1;
				if (score_s1 > best_q) begin
					second_n = best_q;
					best_n   = score_s1;
					bpos_n   = pos_q[IDX_W-1:0];
				end else begin
					second_n = score_s1;
				end
			end else if (score_s1 > best_q) begin
				second_n = best_q;
				best_n   = score_s1;
				bpos_n   = pos_q[IDX_W-1:0];
			end else if (score_s1 > second_q) begin
				second_n = score_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			have2_q <= 1'b0;
			any_q   <= 1'b0;
		end else if (step) begin
			if (last_s1) begin
				pos_q   <= '0;
				have2_q <= 1'b0;
				any_q   <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				have2_q <= have2_n;
				any_q   <= any_n;
			end
		end
	end

	// value registers are qualified by pos_q and have2_q
	always_ff @(posedge clk) begin
		if (step) begin
			best_q   <= best_n;
			second_q <= second_n;
			bpos_q   <= bpos_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s2 <= '0;
		end else if (advance) begin
			flags_s2.valid       <= valid_s1 && last_s1;
			flags_s2.have_second <= have2_n;
			flags_s2.any_above   <= any_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			best_s2     <= best_n;
			second_s2   <= second_n;
			best_pos_s2 <= bpos_n;
		end
	end

endmodule

FILE: design/tmc_result.sv
// Margin, status decision and output register.
`timescale 1ns / 1ps

module tmc_result #(
	parameter int MAX_CLASSES = 64,
	parameter int SCORE_WIDTH = 16,
	localparam int IDX_W = $clog2(MAX_CLASSES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tmc_pkg::row_flags_t           flags_s2,
	input  logic signed [SCORE_WIDTH-1:0] best_s2,
	input  logic signed [SCORE_WIDTH-1:0] second_s2,
	input  logic [IDX_W-1:0]              best_pos_s2,
	input  logic [SCORE_WIDTH-1:0]        margin_buffer,
	output logic                          advance,
	tmc_result_if.source                  result_ch
);
	import tmc_pkg::*;

	logic                             out_valid_q;
	logic [SCORE_WIDTH:0]             diff;
	logic [SCORE_WIDTH-1:0]           margin;
	status_t                          status;
	logic [IDX_W+CLASS_INDEX_W-1:0]   pos_ext;

	// best never falls below second, so the difference fits unsigned
	assign diff    = {best_s2[SCORE_WIDTH-1], best_s2} - {second_s2[SCORE_WIDTH-1], second_s2};
	assign margin  = flags_s2.have_second ? diff[SCORE_WIDTH-1:0] : '1;
	assign pos_ext = {{CLASS_INDEX_W{1'b0}}, best_pos_s2};

	always_comb begin
		if (!flags_s2.any_above) begin
			status = STATUS_NO_ABOVE;
		end else if (margin < margin_buffer) begin
			status = STATUS_LOW_MARGIN;
		end else begin
			status = STATUS_ACCEPT;
		end
	end

	assign advance         = !out_valid_q || result_ch.ready;
	assign result_ch.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= flags_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && flags_s2.valid) begin
			result_ch.status      <= status;
			result_ch.class_index <= pos_ext[CLASS_INDEX_W-1:0];
			result_ch.margin      <= margin;
		end
	end

endmodule

FILE: design/top_two_margin_classifier_top.sv
// Top level of the top-two margin classifier.
`timescale 1ns / 1ps

// channel    role     payload
// score_ch   sink     score (signed Q8.8), last
// result_ch  source   status, class_index, margin (Q8.8)
// cfg_ch     sink     index, data (0 threshold, 1 margin_buffer)
//
// One score request per cycle while no result is held; a last score, once taken,
// reaches result_ch through the row-state and output registers.
// Reset clears row position and flags (not the value registers), both registers and all valid flags.
// A held result stalls the whole pipe; score_ch.ready drops only then.
// Register writes are always taken.

module top_two_margin_classifier_top #(
	parameter int MAX_CLASSES = 64,
	parameter int SCORE_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	tmc_score_if.sink    score_ch,
	tmc_result_if.source result_ch,
	tmc_cfg_if.sink      cfg_ch
);
	import tmc_pkg::*;

	localparam int IDX_W = $clog2(MAX_CLASSES);

	logic signed [SCORE_WIDTH-1:0] threshold_q;
	logic [SCORE_WIDTH-1:0]        margin_buffer_q;
	logic                          advance;
	row_flags_t                    flags_s2;
	logic signed [SCORE_WIDTH-1:0] best_s2;
	logic signed [SCORE_WIDTH-1:0] second_s2;
	logic [IDX_W-1:0]              best_pos_s2;

	tmc_cfg_regs #(
		.SCORE_WIDTH (SCORE_WIDTH)
	) u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_ch          (cfg_ch),
		.threshold_q     (threshold_q),
		.margin_buffer_q (margin_buffer_q)
	);

	tmc_row_track #(
		.MAX_CLASSES (MAX_CLASSES),
		.SCORE_WIDTH (SCORE_WIDTH)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.score_ch    (score_ch),
		.advance     (advance),
		.threshold   (threshold_q),
		.flags_s2    (flags_s2),
		.best_s2     (best_s2),
		.second_s2   (second_s2),
		.best_pos_s2 (best_pos_s2)
	);

	tmc_result #(
		.MAX_CLASSES (MAX_CLASSES),
		.SCORE_WIDTH (SCORE_WIDTH)
	) u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.flags_s2      (flags_s2),
		.best_s2       (best_s2),
		.second_s2     (second_s2),
		.best_pos_s2   (best_pos_s2),
		.margin_buffer (margin_buffer_q),
		.advance       (advance),
		.result_ch     (result_ch)
	);

endmodule

FILE: design/tmc_checker.sv
// Port-level checker for the top-two margin classifier, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmc_checker #(
	parameter int SCORE_WIDTH = 16
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input tmc_pkg::status_t                  status,
	input logic [tmc_pkg::CLASS_INDEX_W-1:0] class_index,
	input logic [SCORE_WIDTH-1:0]            margin
);
	import tmc_pkg::*;

	`ASSERT_IN_RESET(a_rst_idle, clk, arst_n, !out_valid)
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, out_valid, status == STATUS_ACCEPT || status == STATUS_NO_ABOVE || status == STATUS_LOW_MARGIN)
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready && (in_valid || !in_valid))
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(class_index) && $stable(margin))

endmodule

bind top_two_margin_classifier_top tmc_checker #(
	.SCORE_WIDTH (SCORE_WIDTH)
) u_tmc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (score_ch.valid),
	.in_ready    (score_ch.ready),
	.out_valid   (result_ch.valid),
	.out_ready   (result_ch.ready),
	.status      (result_ch.status),
	.class_index (result_ch.class_index),
	.margin      (result_ch.margin)
);

FILE: tb/testbench.sv
// Self-checking bench for the top-two margin classifier: directed table, then random rows.
`timescale 1ns / 1ps

module testbench;
	import tmc_pkg::*;

	localparam int SCORE_W       = 16;
	localparam int MAX_CLASSES   = 64;
	localparam int ABOVE_SAT     = 127;
	localparam int SETTLE        = 4;
	localparam int IDLE_LIMIT    = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_SCORES = 1250;

	typedef struct {
		status_t                  status;
		logic [CLASS_INDEX_W-1:0] class_index;
		logic [SCORE_W-1:0]       margin;
	} verdict_t;

	typedef enum logic {STEP_SCORE, STEP_WRITE} step_kind_t;

	typedef struct {
		step_kind_t         kind;
		cfg_index_t         reg_sel;
		logic [SCORE_W-1:0] value;
		logic               last;
		bit                 typed;
		verdict_t           want;
	} step_t;

	logic clk;
	logic arst_n;

	tmc_score_if  #(.SCORE_WIDTH(SCORE_W)) score_ch ();
	tmc_result_if #(.SCORE_WIDTH(SCORE_W)) result_ch ();
	tmc_cfg_if    #(.SCORE_WIDTH(SCORE_W)) cfg_ch ();

	top_two_margin_classifier_top #(.MAX_CLASSES(MAX_CLASSES), .SCORE_WIDTH(SCORE_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.score_ch(score_ch),
		.result_ch(result_ch),
		.cfg_ch(cfg_ch)
	);

	// classifier state as predicted
	logic signed [SCORE_W-1:0] cut_level;
	logic [SCORE_W-1:0]        gap_floor;
	logic signed [SCORE_W-1:0] lead_score;
	logic signed [SCORE_W-1:0] runner_score;
	int unsigned               lead_pos;
	int unsigned               row_pos;
	int unsigned               above_n;
	bit                        have_runner;

	verdict_t pending_verdicts[$];
	step_t    directed_steps[$];
	verdict_t no_want;

	int fails       = 0;
	int n_scores    = 0;
	int n_rows      = 0;
	int n_checked   = 0;
	int n_writes    = 0;
	int n_long_rows = 0;
	int n_holds     = 0;
	int quiet_cycles = 0;
	bit tx_gaps_on   = 1'b1;
	bit rx_gaps_on   = 1'b1;
	bit hold_results = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void clear_row();
		lead_score   = '0;
		runner_score = '0;
		lead_pos     = 0;
		row_pos      = 0;
		above_n      = 0;
		have_runner  = 1'b0;
	endfunction

	// Returns 1 when the score closes a row; v then holds the expected result.
	function automatic bit rank_score(input logic signed [SCORE_W-1:0] s, input logic l,
		output verdict_t v);
		int gap;
		if (row_pos < MAX_CLASSES) begin
			if (s > cut_level && above_n < ABOVE_SAT)
				above_n++;
			if (row_pos == 0) begin
				lead_score = s;
				lead_pos   = 0;
			end else if (s > lead_score) begin
				runner_score = lead_score;
				lead_score   = s;
				lead_pos     = row_pos;
			end else if (!have_runner || s > runner_score) begin
				runner_score = s;
			end
			if (row_pos != 0)
				have_runner = 1'b1;
			row_pos++;
		end
		if (!l)
			return 1'b0;
		if (have_runner) begin
			gap = int'(lead_score) - int'(runner_score);
			v.margin = (gap < 0) ? '0 : gap[SCORE_W-1:0];
		end else begin
			v.margin = '1;
		end
		if (above_n == 0)
			v.status = STATUS_NO_ABOVE;
		else if (v.margin < gap_floor)
			v.status = STATUS_LOW_MARGIN;
		else
			v.status = STATUS_ACCEPT;
		v.class_index = lead_pos[CLASS_INDEX_W-1:0];
		clear_row();
		return 1'b1;
	endfunction

	function automatic step_t score_step(logic [SCORE_W-1:0] value, logic last);
		step_t st;
		st.kind              = STEP_SCORE;
		st.reg_sel           = CFG_THRESHOLD;
		st.value             = value;
		st.last              = last;
		st.typed             = 1'b0;
		st.want.status       = STATUS_ACCEPT;
		st.want.class_index  = '0;
		st.want.margin       = '0;
		return st;
	endfunction

	function automatic void put_score(logic [SCORE_W-1:0] value, logic last);
		directed_steps.push_back(score_step(value, last));
	endfunction

	function automatic void put_row_end(logic [SCORE_W-1:0] value, status_t st_code,
		logic [CLASS_INDEX_W-1:0] idx, logic [SCORE_W-1:0] mg);
		step_t st;
		st                  = score_step(value, 1'b1);
		st.typed            = 1'b1;
		st.want.status      = st_code;
		st.want.class_index = idx;
		st.want.margin      = mg;
		directed_steps.push_back(st);
	endfunction

	function automatic void put_write(cfg_index_t sel, logic [SCORE_W-1:0] data);
		step_t st;
		st         = score_step(data, 1'b0);
		st.kind    = STEP_WRITE;
		st.reg_sel = sel;
		directed_steps.push_back(st);
	endfunction

	task automatic wait_idle();
		@(negedge clk);
		score_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t sel, input logic [SCORE_W-1:0] data);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= sel;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (sel == CFG_THRESHOLD)
			cut_level = data;
		else
			gap_floor = data;
		n_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_score(input logic [SCORE_W-1:0] s, input logic l, input bit typed,
		input verdict_t want);
		verdict_t v;
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, 17) : 0;
		@(negedge clk);
		if (gap > 0) begin
			score_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		score_ch.valid <= 1'b1;
		score_ch.score <= s;
		score_ch.last  <= l;
		do @(posedge clk); while (!score_ch.ready);
		n_scores++;
		if (rank_score(s, l, v)) begin
			pending_verdicts.push_back(typed ? want : v);
			n_rows++;
		end
	endtask

	task automatic send_random_row(input int len);
		int style;
		logic [SCORE_W-1:0] s;
		style = $urandom_range(0, 3);
		if (len > MAX_CLASSES)
			n_long_rows++;
		for (int k = 0; k < len; k++) begin
			case (style)
				0: s = SCORE_W'($urandom_range(0, 16'hFFFF));
				1: s = SCORE_W'(cut_level + $urandom_range(0, 8) - 4);
				2: s = SCORE_W'(cut_level + ($urandom_range(0, 3) << 7));
				default: s = $urandom_range(0, 1) ? SCORE_W'(16'h7FFF - $urandom_range(0, 3))
					: SCORE_W'(16'h8000 + $urandom_range(0, 3));
			endcase
			if ($urandom_range(0, 15) == 0)
				s = SCORE_W'($urandom_range(0, 16'hFFFF));
			send_score(s, k == len - 1, 1'b0, no_want);
		end
	endtask

	// result side: random back-pressure, one long hold on request
	initial begin
		int gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = rx_gaps_on ? $urandom_range(0, 17) : 0;
			if (hold_results) begin
				gap          = HOLD_CYCLES;
				hold_results = 1'b0;
				n_holds++;
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result with no row pending: status %0d class_index %0d margin %h",
					result_ch.status, result_ch.class_index, result_ch.margin);
				fails++;
			end else begin
				want = pending_verdicts.pop_front();
				n_checked++;
				if (result_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_ch.status);
					fails++;
				end
				if (result_ch.class_index !== want.class_index) begin
					$error("class_index: expected %0d, got %0d", want.class_index,
						result_ch.class_index);
					fails++;
				end
				if (result_ch.margin !== want.margin) begin
					$error("margin: expected %h, got %h", want.margin, result_ch.margin);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((score_ch.valid && score_ch.ready) || (result_ch.valid && result_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_verdicts.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int phase;
		int phase_target;
		int random_start;
		int len;
		int pick;
		logic [SCORE_W-1:0] thr_pick;
		logic [SCORE_W-1:0] buf_pick;

		arst_n         = 1'b0;
		score_ch.valid = 1'b0;
		score_ch.score = '0;
		score_ch.last  = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = CFG_THRESHOLD;
		cfg_ch.data    = '0;
		cut_level      = '0;
		gap_floor      = '0;
		clear_row();

		// defaults after reset: threshold 0, margin buffer 0
		put_row_end(16'h7FFF, STATUS_ACCEPT, 6'd0, 16'hFFFF);
		put_row_end(16'h8000, STATUS_NO_ABOVE, 6'd0, 16'hFFFF);
		put_score(16'h8000, 1'b0);
		put_row_end(16'h7FFF, STATUS_ACCEPT, 6'd1, 16'hFFFF);
		put_score(16'h0100, 1'b0);
		put_row_end(16'h0100, STATUS_ACCEPT, 6'd0, 16'h0000);
		put_score(16'h0000, 1'b0);
		put_row_end(16'h0000, STATUS_NO_ABOVE, 6'd0, 16'h0000);
		put_score(16'h0001, 1'b0);
		put_score(16'h8000, 1'b1);
		put_score(16'h0100, 1'b0);
		put_score(16'h0300, 1'b0);
		put_score(16'h0200, 1'b0);
		put_score(16'hFF00, 1'b1);
		put_write(CFG_MARGIN_BUFFER, 16'h0100);
		put_score(16'h0200, 1'b0);
		put_row_end(16'h0180, STATUS_LOW_MARGIN, 6'd0, 16'h0080);
		put_write(CFG_THRESHOLD, 16'h7FFF);
		put_row_end(16'h7FFF, STATUS_NO_ABOVE, 6'd0, 16'hFFFF);
		put_write(CFG_THRESHOLD, 16'h8000);
		put_score(16'h8000, 1'b0);
		put_row_end(16'h8001, STATUS_LOW_MARGIN, 6'd1, 16'h0001);
		put_write(CFG_MARGIN_BUFFER, 16'hFFFF);
		put_row_end(16'h0000, STATUS_ACCEPT, 6'd0, 16'hFFFF);
		put_score(16'h1234, 1'b0);
		put_score(16'h1000, 1'b0);
		put_score(16'h1233, 1'b1);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_WRITE)
				write_register(directed_steps[i].reg_sel, directed_steps[i].value);
			else
				send_score(directed_steps[i].value, directed_steps[i].last,
					directed_steps[i].typed, directed_steps[i].want);
		end

		phase        = 0;
		random_start = n_scores;
		while (n_scores - random_start < RANDOM_SCORES) begin
			case ($urandom_range(0, 4))
				0: thr_pick = 16'h8000;
				1: thr_pick = 16'h7FFF;
				2: thr_pick = 16'h0000;
				3: thr_pick = SCORE_W'($urandom_range(0, 16'hFFFF));
				default: thr_pick = SCORE_W'($urandom_range(0, 1023) - 512);
			endcase
			case ($urandom_range(0, 3))
				0: buf_pick = 16'h0000;
				1: buf_pick = 16'hFFFF;
				2: buf_pick = SCORE_W'($urandom_range(0, 16'h0300));
				default: buf_pick = SCORE_W'($urandom_range(0, 16'hFFFF));
			endcase
			write_register(CFG_THRESHOLD, thr_pick);
			write_register(CFG_MARGIN_BUFFER, buf_pick);
			tx_gaps_on = $urandom_range(0, 2) != 0;
			rx_gaps_on = $urandom_range(0, 2) != 0;
			if (phase == 2) begin
				// back-to-back one-score rows against a long result hold
				tx_gaps_on   = 1'b0;
				hold_results = 1'b1;
				repeat (80)
					send_score(SCORE_W'($urandom_range(0, 16'hFFFF)), 1'b1, 1'b0, no_want);
			end else begin
				phase_target = n_scores + $urandom_range(100, 220);
				while (n_scores < phase_target) begin
					pick = $urandom_range(0, 19);
					if (pick == 0)
						len = 1;
					else if (pick == 1)
						len = $urandom_range(MAX_CLASSES, MAX_CLASSES + 6);
					else if (pick == 2)
						len = $urandom_range(20, MAX_CLASSES - 1);
					else
						len = $urandom_range(2, 8);
					send_random_row(len);
				end
			end
			phase++;
		end

		wait_idle();
		repeat (2 * SETTLE) @(posedge clk);

		$display("Covered %0d scores in %0d rows (%0d rows past %0d classes), %0d results checked.",
			n_scores, n_rows, n_long_rows, MAX_CLASSES, n_checked);
		$display("%0d register writes over %0d random settings, %0d long result holds, %0d errors.",
			n_writes, phase, n_holds, fails);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
